### rtl/fqre_pkg.sv
// Shared types and codes for the free-slot quarantine block.
// Used by the front, back and top-level modules; depends on nothing.
package fqre_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned SizeW = 32;
  localparam int unsigned HeldW = 37;
  localparam int unsigned OutCntW = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [2:0] KIND_EVICT = 3'd0;
  localparam logic [2:0] KIND_ACCEPT = 3'd1;
  localparam logic [2:0] KIND_REJECT = 3'd2;
  localparam logic [2:0] KIND_BYPASS = 3'd3;
  localparam logic [2:0] KIND_PURGE = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_CAPACITY = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DEFERRED = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ENABLED = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PAUSED = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ZAPPING = 3'd4;

  typedef enum logic [1:0] {
    CLS_PURGE,
    CLS_BYPASS,
    CLS_REJECT,
    CLS_INSERT
  } cls_e;

  typedef struct packed {
    logic             func;
    logic [AddrW-1:0] slot_addr;
    logic [SizeW-1:0] slot_size;
    logic             direct_mapped;
    logic [31:0]      random_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [AddrW-1:0]   out_addr;
    logic [SizeW-1:0]   entry_size;
    logic               zap;
    logic [HeldW-1:0]   held_bytes;
    logic [OutCntW-1:0] held_count;
    logic [31:0]        miss_total;
    logic               last;
  } result_t;

  typedef struct packed {
    cls_e             cls;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
    logic [31:0]      rnd;
    logic [SizeW-1:0] target;
    logic             deferred;
    logic             zap;
  } work_t;

endpackage

### rtl/fqre_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqre_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fqre_mod.sv
// Bit-serial remainder unit: dividend modulo a small divisor, one bit a cycle.
// No dependencies.
module fqre_mod #(
  parameter int unsigned DivW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [31:0]     dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] rem_o
);

  logic            run_q, run_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [31:0]     dvd_q, dvd_d;
  logic [DivW-1:0] div_q, div_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW:0]   trial;
  logic            done;

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    div_d = div_q;
    rem_d = rem_q;
    done = 1'b0;
    trial = {rem_q, dvd_q[31]};
    if (trial >= {1'b0, div_q}) begin
      trial = trial - {1'b0, div_q};
    end
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      div_d = divisor_i;
      rem_d = '0;
    end else if (run_q) begin
      rem_d = trial[DivW-1:0];
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_d = 1'b0;
        done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done;
  assign rem_o = rem_d;

endmodule

### rtl/fqre_front.sv
// Front end: configuration registers, request classification and a two-item queue.
// Depends on fqre_pkg.
module fqre_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  fqre_pkg::req_t                  req_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fqre_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fqre_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                            q_valid_o,
  output fqre_pkg::work_t                 q_item_o,
  input  logic                            q_pop_i
);

  logic [fqre_pkg::SizeW-1:0] cap_q;
  logic deferred_q, enabled_q, paused_q, zapping_q;

  fqre_pkg::work_t slot_q [2];
  fqre_pkg::work_t item;
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign cfg_ready_o = 1'b1;
  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;
  assign pop = q_pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
      deferred_q <= 1'b0;
      enabled_q <= 1'b0;
      paused_q <= 1'b0;
      zapping_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fqre_pkg::REG_CAPACITY: cap_q <= cfg_data_i;
        fqre_pkg::REG_DEFERRED: deferred_q <= cfg_data_i[0];
        fqre_pkg::REG_ENABLED: enabled_q <= cfg_data_i[0];
        fqre_pkg::REG_PAUSED: paused_q <= cfg_data_i[0];
        fqre_pkg::REG_ZAPPING: zapping_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.addr = req_i.slot_addr;
    item.size = req_i.slot_size;
    item.rnd = req_i.random_value;
    item.target = cap_q - req_i.slot_size;
    item.deferred = deferred_q;
    item.zap = zapping_q;
    priority if (req_i.func) begin
      item.cls = fqre_pkg::CLS_PURGE;
    end else if (!enabled_q || paused_q || req_i.direct_mapped) begin
      item.cls = fqre_pkg::CLS_BYPASS;
    end else if (cap_q < req_i.slot_size) begin
      item.cls = fqre_pkg::CLS_REJECT;
    end else begin
      item.cls = fqre_pkg::CLS_INSERT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = slot_q[rd_ptr_q];

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("Queue fill count out of range.");
`endif

endmodule

### rtl/fqre_back.sv
// Back end: runs queued items against the entry table and emits results.
// Depends on fqre_pkg, fqre_ram and fqre_mod.
module fqre_back #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned MAX_EVICT_PER_INSERT = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  fqre_pkg::work_t     q_item_i,
  output logic                q_pop_o,
  output logic                result_valid_o,
  output fqre_pkg::result_t   result_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned EntW = fqre_pkg::AddrW + fqre_pkg::SizeW;
  localparam int unsigned HeldW = fqre_pkg::HeldW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PCHK = 3'd1;
  localparam logic [2:0] S_PEV = 3'd2;
  localparam logic [2:0] S_ICHK = 3'd3;
  localparam logic [2:0] S_IEV = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_SW1 = 3'd6;
  localparam logic [2:0] S_SW2 = 3'd7;

  logic [2:0] state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [HeldW-1:0] held_q, held_d;
  logic [31:0] miss_q, miss_d;
  logic [CntW-1:0] evict_q, evict_d;
  fqre_pkg::work_t cur_q, cur_d;
  logic res_valid_q, res_valid_d;
  fqre_pkg::result_t res_q, res_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EntW-1:0] wdata, rdata;
  logic [fqre_pkg::AddrW-1:0] rd_addr;
  logic [fqre_pkg::SizeW-1:0] rd_size;
  logic div_start, div_done;
  logic [CntW-1:0] pick;
  logic full, over;
  logic [CntW-1:0] back_idx;

  assign rd_addr = rdata[EntW-1:fqre_pkg::SizeW];
  assign rd_size = rdata[fqre_pkg::SizeW-1:0];
  assign back_idx = count_q - 1'b1;
  assign full = (32'(count_q) >= 32'(TABLE_DEPTH));
  assign over = (held_q > HeldW'(cur_q.target)) &&
                (!cur_q.deferred || (32'(evict_q) < 32'(MAX_EVICT_PER_INSERT)));

  fqre_ram #(
    .WIDTH(EntW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  fqre_mod #(
    .DivW(CntW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_q.rnd),
    .divisor_i  (count_q + 1'b1),
    .done_o     (div_done),
    .rem_o      (pick)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    held_d = held_q;
    miss_d = miss_q;
    evict_d = evict_q;
    cur_d = cur_q;
    res_valid_d = 1'b0;
    res_d = res_q;
    q_pop_o = 1'b0;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d = q_item_i;
          evict_d = '0;
          unique case (q_item_i.cls)
            fqre_pkg::CLS_PURGE: state_d = S_PCHK;
            fqre_pkg::CLS_INSERT: state_d = S_ICHK;
            fqre_pkg::CLS_REJECT: begin
              miss_d = miss_q + 32'd1;
              res_valid_d = 1'b1;
              res_d.kind = fqre_pkg::KIND_REJECT;
              res_d.out_addr = q_item_i.addr;
              res_d.entry_size = q_item_i.size;
              res_d.last = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
              res_d.kind = fqre_pkg::KIND_BYPASS;
              res_d.out_addr = q_item_i.addr;
              res_d.entry_size = q_item_i.size;
              res_d.last = 1'b1;
            end
          endcase
        end
      end
      S_PCHK: begin
        if (count_q != '0) begin
          raddr = back_idx[AW-1:0];
          count_d = back_idx;
          state_d = S_PEV;
        end else begin
          res_valid_d = 1'b1;
          res_d.kind = fqre_pkg::KIND_PURGE;
          res_d.out_addr = '0;
          res_d.entry_size = '0;
          res_d.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PEV, S_IEV: begin
        held_d = held_q - HeldW'(rd_size);
        res_valid_d = 1'b1;
        res_d.kind = fqre_pkg::KIND_EVICT;
        res_d.out_addr = rd_addr;
        res_d.entry_size = rd_size;
        res_d.last = 1'b0;
        state_d = (state_q == S_PEV) ? S_PCHK : S_ICHK;
      end
      S_ICHK: begin
        if ((count_q != '0) && (full || over)) begin
          raddr = back_idx[AW-1:0];
          count_d = back_idx;
          evict_d = evict_q + 1'b1;
          state_d = S_IEV;
        end else begin
          div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          raddr = pick[AW-1:0];
          state_d = S_SW1;
        end
      end
      S_SW1: begin
        we = 1'b1;
        waddr = count_q[AW-1:0];
        wdata = rdata;
        state_d = S_SW2;
      end
      default: begin
        we = 1'b1;
        waddr = pick[AW-1:0];
        wdata = {cur_q.addr, cur_q.size};
        count_d = count_q + 1'b1;
        held_d = held_q + HeldW'(cur_q.size);
        res_valid_d = 1'b1;
        res_d.kind = fqre_pkg::KIND_ACCEPT;
        res_d.out_addr = cur_q.addr;
        res_d.entry_size = cur_q.size;
        res_d.last = 1'b1;
        state_d = S_IDLE;
      end
    endcase
    res_d.zap = (res_d.kind == fqre_pkg::KIND_ACCEPT) && cur_q.zap;
    res_d.held_bytes = held_d;
    res_d.held_count = fqre_pkg::OutCntW'(count_d);
    res_d.miss_total = miss_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      held_q <= '0;
      miss_q <= '0;
      evict_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      held_q <= held_d;
      miss_q <= miss_d;
      evict_q <= evict_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(count_q) <= 32'(TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (res_valid_q && !res_q.last) |-> (res_q.kind == fqre_pkg::KIND_EVICT))
    else $error("Only evictions may precede the final result of an item.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (res_valid_q && res_q.kind != fqre_pkg::KIND_ACCEPT) |-> !res_q.zap)
    else $error("Zap set on a result other than an accepted slot.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_SW2) |-> (32'(pick) <= 32'(count_q)))
    else $error("Swap position beyond the new entry.");
`endif

endmodule

### rtl/free_quarantine_random_evict.sv
// Top level of the free-slot quarantine with random placement.
// Depends on fqre_pkg, fqre_front and fqre_back.
//
// A request is taken when start is high and busy is low; up to two requests wait
// in a queue while the back end works. Every result appears for exactly one cycle
// with result_valid_o and cannot be stalled. A bypassed or rejected free gets its
// result straight from idle; a purge evicts every held entry from the table's back;
// an insert evicts back entries while the table is full or over target, then swaps
// in at a slot from the one-bit-per-cycle remainder unit and registered RAM read.
module free_quarantine_random_evict #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned MAX_EVICT_PER_INSERT = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  fqre_pkg::req_t                req_i,
  output logic                          result_valid_o,
  output fqre_pkg::result_t             result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fqre_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fqre_pkg::CfgDataW-1:0] cfg_data_i
);

  logic q_valid, q_pop;
  fqre_pkg::work_t q_item;

  fqre_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  fqre_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_EVICT_PER_INSERT(MAX_EVICT_PER_INSERT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
